// ----- rtl/mrf_pkg.sv -----
// Shared types and constants of the Modbus RTU request framer.
// Used by every module under rtl; depends on nothing else.
package mrf_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_READ       = 2'd0;
	localparam logic [1:0] OP_WRITE_HDR  = 2'd1;
	localparam logic [1:0] OP_WRITE_DATA = 2'd2;

	// Modbus function codes and CRC-16 constants.
	localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
	localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] CRC_START       = 16'hFFFF;

	// Largest register count accepted by a write header.
	localparam int unsigned MAX_WRITE_REGS = 123;

	// Position of a result within one input item (up to nine results).
	localparam int unsigned MAX_STEPS = 9;
	localparam int unsigned IDX_W     = $clog2(MAX_STEPS);

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  slave_addr;
		logic [15:0] start_addr;
		logic [15:0] reg_count;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
		logic       run_end;
		logic       error;
	} result_t;

endpackage

// ----- rtl/mrf_in_stage.sv -----
// Input register of the request framer: holds one accepted word until
// the frame builder has produced all of its results. Depends on mrf_pkg.
module mrf_in_stage import mrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        take,
	output logic        item_valid,
	output item_t       item
);

	logic  valid_s1;
	item_t item_s1;

	// The slot frees up in the same cycle the builder retires its word.
	assign s_tready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op         <= s_tuser;
			item_s1.slave_addr <= s_tdata[7:0];
			item_s1.start_addr <= s_tdata[23:8];
			item_s1.reg_count  <= s_tdata[39:24];
			item_s1.data_byte  <= s_tdata[47:40];
		end
	end

endmodule

// ----- rtl/mrf_builder.sv -----
// Frame builder: walks the held word one result per step, keeps the
// running CRC and the open-write state. Depends on mrf_pkg.
module mrf_builder import mrf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  item_t   item,
	input  logic    adv,
	output logic    emit,
	output result_t res,
	output logic    take
);

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic [7:0]       bytes_left_q;
	logic             write_open_q;

	logic        step;
	logic        is_hdr;
	logic        oversize;
	logic [7:0]  byte_cnt;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic [7:0]  hdr_byte;
	logic        do_emit;
	logic        is_data;
	logic        is_crc_lo;
	logic        is_crc_hi;
	logic        is_err;
	logic        last;
	logic        run_end;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	assign step     = item_valid && adv;
	assign is_hdr   = (item.op == OP_READ) || (item.op == OP_WRITE_HDR);
	assign oversize = (item.op == OP_WRITE_HDR) && (item.reg_count > 16'(MAX_WRITE_REGS));
	// The count never exceeds 127 here, so doubling fits the byte.
	assign byte_cnt = {item.reg_count[6:0], 1'b0};
	// A header restarts the CRC at its first byte.
	assign crc_base = (is_hdr && idx_q == '0) ? CRC_START : crc_q;

	// Header bytes of read and write requests; the byte count is sent by write headers only.
	always_comb begin
		unique case (idx_q)
			IDX_W'(0): hdr_byte = item.slave_addr;
			IDX_W'(1): hdr_byte = (item.op == OP_READ) ? FN_READ_HOLDING : FN_WRITE_MULTI;
			IDX_W'(2): hdr_byte = item.start_addr[15:8];
			IDX_W'(3): hdr_byte = item.start_addr[7:0];
			IDX_W'(4): hdr_byte = item.reg_count[15:8];
			IDX_W'(5): hdr_byte = item.reg_count[7:0];
			default:   hdr_byte = byte_cnt;
		endcase
	end

	always_comb begin
		do_emit   = 1'b1;
		is_data   = 1'b0;
		is_crc_lo = 1'b0;
		is_crc_hi = 1'b0;
		is_err    = 1'b0;
		last      = 1'b0;
		run_end   = 1'b0;
		unique case (item.op)
			OP_READ: begin
				if (idx_q < IDX_W'(6)) begin
					is_data = 1'b1;
				end else if (idx_q == IDX_W'(6)) begin
					is_crc_lo = 1'b1;
				end else begin
					is_crc_hi = 1'b1;
				end
			end
			OP_WRITE_HDR: begin
				if (oversize) begin
					is_err = 1'b1;
				end else if (idx_q < IDX_W'(7)) begin
					is_data = 1'b1;
					// A nonzero count leaves the frame open for data words.
					if (idx_q == IDX_W'(6) && item.reg_count != '0) begin
						last    = 1'b1;
						run_end = 1'b1;
					end
				end else if (idx_q == IDX_W'(7)) begin
					is_crc_lo = 1'b1;
				end else begin
					is_crc_hi = 1'b1;
				end
			end
			OP_WRITE_DATA: begin
				if (idx_q == '0) begin
					if (!write_open_q) begin
						is_err = 1'b1;
					end else begin
						is_data = 1'b1;
						if (bytes_left_q != 8'd1) begin
							last    = 1'b1;
							run_end = 1'b1;
						end
					end
				end else if (idx_q == IDX_W'(1)) begin
					is_crc_lo = 1'b1;
				end else begin
					is_crc_hi = 1'b1;
				end
			end
			default: begin
				// Unused selector: retire the word without a result.
				do_emit = 1'b0;
				last    = 1'b1;
			end
		endcase
		if (is_err || is_crc_hi) begin
			last    = 1'b1;
			run_end = 1'b1;
		end
	end

	always_comb begin
		res.frame_byte = 8'h00;
		crc_next       = crc_base;
		if (is_data) begin
			res.frame_byte = (item.op == OP_WRITE_DATA) ? item.data_byte : hdr_byte;
			crc_next       = crc_byte(crc_base, res.frame_byte);
		end else if (is_crc_lo) begin
			res.frame_byte = crc_base[7:0];
		end else if (is_crc_hi) begin
			res.frame_byte = crc_base[15:8];
			crc_next       = CRC_START;
		end
		res.frame_end = is_crc_hi;
		res.run_end   = run_end;
		res.error     = is_err;
	end

	assign emit = step && do_emit;
	assign take = step && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			crc_q        <= CRC_START;
			bytes_left_q <= '0;
			write_open_q <= 1'b0;
		end else if (step) begin
			idx_q <= last ? '0 : idx_q + IDX_W'(1);
			crc_q <= crc_next;
			if (is_hdr && idx_q == '0) begin
				write_open_q <= 1'b0;
				bytes_left_q <= '0;
			end
			if (item.op == OP_WRITE_HDR && !oversize && idx_q == IDX_W'(6)
					&& item.reg_count != '0) begin
				write_open_q <= 1'b1;
				bytes_left_q <= byte_cnt;
			end
			if (item.op == OP_WRITE_DATA && idx_q == '0 && write_open_q) begin
				bytes_left_q <= bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					write_open_q <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(MAX_STEPS))
		else $error("builder step index out of range");
	a_open_owes: assert property (@(posedge clk) disable iff (!arst_n)
		write_open_q |-> bytes_left_q != '0)
		else $error("open write owes no data bytes");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid |-> idx_q == '0)
		else $error("step index left mid-word with no word held");
	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_crc_hi) |=> crc_q == CRC_START)
		else $error("CRC not restarted after frame end");
`endif

endmodule

// ----- rtl/mrf_out_reg.sv -----
// Output register of the request framer: holds one result word for the
// master-side stream and tells the builder when it may step. Depends on mrf_pkg.
module mrf_out_reg import mrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       emit,
	input  result_t    res,
	output logic       adv,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [1:0] m_tuser
);

	logic    valid_q;
	result_t res_q;

	assign adv      = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.frame_byte;
	assign m_tlast  = res_q.frame_end;
	assign m_tuser  = {res_q.error, res_q.run_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res;
		end
	end

endmodule

// ----- rtl/modbus_rtu_request_framer_unit.sv -----
// Top level of the Modbus RTU request framer.
// Instantiates mrf_in_stage, mrf_builder and mrf_out_reg; depends on mrf_pkg.
//
// The slave-side stream takes one request word per handshake: a read holding
// registers request, a write multiple header, or one write data byte. The
// master-side stream gives one frame byte per word, with the reflected CRC-16
// appended low byte first; tlast marks the CRC high byte that closes a frame.
// A stray data byte or an oversize write count gives a single error word.
// The first result word of an accepted word passes through the input register,
// the combinational builder and the output register. Throughput: one result
// word per cycle while the receiver takes them. A read gives 8 result words,
// a write header 7 (9 with a zero count), a data byte 1 (3 for the last one)
// and an error word 1; the unused selector gives no result. The builder steps
// once per free output slot. A new word is accepted in the cycle the previous
// one retires, so words follow each other without a gap.
// Reset clears both stream registers, closes any open write and restarts the
// CRC. When the receiver stalls, the output word holds, the builder stops, and
// one further word can still wait in the input register.
module modbus_rtu_request_framer_unit import mrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: slave_addr[7:0], start_addr[15:0], reg_count[15:0],
	// data_byte[7:0].
	input  logic [47:0] s_tdata,
	// Fields from bit 0: operation[1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: frame_byte[7:0].
	output logic [7:0]  m_tdata,
	// Carries frame_end.
	output logic        m_tlast,
	// Fields from bit 0: run_end, error.
	output logic [1:0]  m_tuser
);

	item_t   item;
	logic    item_valid;
	logic    take;
	logic    emit;
	logic    adv;
	result_t res;

	mrf_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	mrf_builder u_builder (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.adv        (adv),
		.emit       (emit),
		.res        (res),
		.take       (take)
	);

	mrf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.res      (res),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
